### hw/rtl/twmm_pkg.sv
// ----------------------------------------------------------------------------
// Temperature window package
// Shared constants, types and the unit conversion for the windowed
// minimum/maximum temperature tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package twmm_pkg;

  localparam int WINDOW_LEN_DEF = 10;

  localparam int RAW_W    = 16;
  localparam int SAMPLE_W = 9;
  localparam int TEMP_W   = 10;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 32;

  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_TOGGLE  = 1'b1;

  localparam logic [1:0] SEL_CUR = 2'd0;
  localparam logic [1:0] SEL_LO  = 2'd1;
  localparam logic [1:0] SEL_HI  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FILL = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_CONV = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TEMP_W-1:0]   temp_t;

  // Byte from bits 11..4; values above 128 wrap to negative.
  function automatic sample_t decode_reading(input logic [RAW_W-1:0] raw);
    logic [7:0] b;
    b = raw[11:4];
    decode_reading = (b > 8'd128) ? sample_t'({1'b1, b}) : sample_t'({1'b0, b});
  endfunction

  // In Fahrenheit mode, the tenths value 18*c + 320 is divided by ten through a reciprocal multiply.
  // Non-negative values round half up, negative values truncate toward zero; Celsius passes through.
  function automatic temp_t to_unit(input sample_t c, input logic fahr);
    logic signed [13:0] t;
    logic [11:0] x;
    logic [24:0] p;
    logic [8:0]  q;
    t = (14'(c) <<< 4) + (14'(c) <<< 1) + 14'sd320;
    if (t >= 14'sd0) begin
      x = 12'(t + 14'sd5);
    end else begin
      x = 12'(-t);
    end
    p = 25'(x) * 25'd6554;
    q = p[24:16];
    if (!fahr) begin
      to_unit = temp_t'(c);
    end else if (t >= 14'sd0) begin
      to_unit = temp_t'({1'b0, q});
    end else begin
      to_unit = temp_t'(-$signed({1'b0, q}));
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/temperature_window_min_max.sv
// ----------------------------------------------------------------------------
// Temperature window minimum/maximum
// Decodes thermometer readings into whole degrees, keeps a ring of the last
// WINDOW_LEN samples and reports the newest, smallest and largest sample in
// Celsius or Fahrenheit. Toggle transactions flip the display unit.
// ----------------------------------------------------------------------------
// A reading is written into the ring, then the ring is scanned through its
// single read port (states ST_SCAN, ST_CONV, ST_OUT); the first reading after
// reset instead writes every ring entry (ST_FILL) before ST_CONV and ST_OUT.
// A new transaction is taken only in ST_IDLE, after the previous result has
// left ST_OUT, so a stalled result holds off input; a toggle yields no result.
// Reset selects Fahrenheit, empties the window and drops any pending result.
`default_nettype none

module temperature_window_min_max #(
  parameter int WINDOW_LEN = twmm_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [15:0] raw_reading
  input  wire logic [twmm_pkg::TDATA_IN_W-1:0]  s_tdata,
  // [0] kind
  input  wire logic [0:0]                       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [9:0] current_temp, [19:10] window_min, [29:20] window_max, [31:30] zero
  output logic [twmm_pkg::TDATA_OUT_W-1:0]      m_tdata,
  // [0] in_fahrenheit
  output logic [0:0]                            m_tuser
);
  import twmm_pkg::*;

  localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CW = $clog2(WINDOW_LEN + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(WINDOW_LEN - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(WINDOW_LEN);
  localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_LEN - 1);

  state_t state;
  logic [CW-1:0] cnt;
  logic [1:0] sel;
  logic [AW-1:0] write_slot;
  logic ring_filled;
  logic fahrenheit_mode;
  sample_t cur, lo, hi;
  temp_t res_cur, res_lo, res_hi;

  sample_t ring [WINDOW_LEN];
  sample_t rd_data;
  logic rd_en;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  sample_t wr_data;

  logic accept;
  logic is_reading;
  sample_t in_sample;
  sample_t conv_in;
  temp_t conv_out;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign is_reading = (s_tuser[0] == KIND_READING);
  assign in_sample  = decode_reading(s_tdata);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = write_slot;
    wr_data = in_sample;
    if (accept && is_reading && ring_filled) begin
      wr_en = 1'b1;
    end else if (state == ST_FILL) begin
      wr_en   = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_data = cur;
    end
  end

  assign rd_en = (state == ST_SCAN) && (cnt != CNT_END);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= ring[cnt[AW-1:0]];
    end
  end

  always_comb begin
    unique case (sel)
      SEL_CUR: conv_in = cur;
      SEL_LO:  conv_in = lo;
      default: conv_in = hi;
    endcase
  end

  assign conv_out = to_unit(conv_in, fahrenheit_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= '0;
      sel             <= SEL_CUR;
      write_slot      <= '0;
      ring_filled     <= 1'b0;
      fahrenheit_mode <= 1'b1;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!is_reading) begin
              fahrenheit_mode <= !fahrenheit_mode;
            end else begin
              cur <= in_sample;
              lo  <= in_sample;
              hi  <= in_sample;
              cnt <= '0;
              if (!ring_filled) begin
                state <= ST_FILL;
              end else begin
                state      <= ST_SCAN;
                write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + 1'b1;
              end
            end
          end
        end
        ST_FILL: begin
          if (cnt == CNT_LAST) begin
            ring_filled <= 1'b1;
            write_slot  <= (SLOT_LAST == '0) ? '0 : AW'(1);
            sel         <= SEL_CUR;
            state       <= ST_CONV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SCAN: begin
          if (cnt != '0) begin
            if (rd_data < lo) begin
              lo <= rd_data;
            end
            if (rd_data > hi) begin
              hi <= rd_data;
            end
          end
          if (cnt == CNT_END) begin
            sel   <= SEL_CUR;
            state <= ST_CONV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_CONV: begin
          unique case (sel)
            SEL_CUR: res_cur <= conv_out;
            SEL_LO:  res_lo  <= conv_out;
            default: res_hi  <= conv_out;
          endcase
          if (sel == SEL_HI) begin
            state <= ST_OUT;
          end else begin
            sel <= sel + 1'b1;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_hi, res_lo, res_cur};
            m_tuser  <= fahrenheit_mode;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result appeared outside the output state");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (lo <= cur) && (cur <= hi))
    else $error("window minimum, newest and maximum out of order");

  a_reading_starts_work: assert property (@(posedge clk) disable iff (rst)
    (accept && is_reading) |=> (state == ST_FILL) || (state == ST_SCAN))
    else $error("accepted reading did not start processing");

  a_filled_sticks: assert property (@(posedge clk) disable iff (rst)
    ring_filled |=> ring_filled)
    else $error("ring filled flag cleared outside reset");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    ring_filled |-> (write_slot <= SLOT_LAST))
    else $error("write slot beyond window");

endmodule

`default_nettype wire
